/* rtl/core/mps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mps_pkg;

  localparam int ANGLE_BITS_DEF = 16;

  localparam int POS_W   = 32;
  localparam int HEAD_W  = 16;
  localparam int COST_W  = 32;
  localparam int PPRIM_W = 4;
  localparam int REQ_W   = 3;
  localparam int STEP_W  = 17;

  localparam int PEN_W    = 16;
  localparam int PEN_FRAC = 12;
  localparam int PCOST_W  = 29;
  localparam int NUM_PEN  = 3;

  localparam int Q30      = 30;
  localparam int POLY_W   = 32;
  localparam int MUL_W    = 31;
  localparam int TRIG_W   = 32;
  localparam int DX_W     = 18;
  localparam int DY_W     = 15;
  localparam int ROT_W    = 50;
  localparam int NUM_POLY = 5;

  localparam int CFG_IDX_W = 2;

  localparam int IN_X_LSB     = 0;
  localparam int IN_Y_LSB     = IN_X_LSB + POS_W;
  localparam int IN_HEAD_LSB  = IN_Y_LSB + POS_W;
  localparam int IN_COST_LSB  = IN_HEAD_LSB + HEAD_W;
  localparam int IN_PPRIM_LSB = IN_COST_LSB + COST_W;
  localparam int IN_PRIM_LSB  = IN_PPRIM_LSB + PPRIM_W;
  localparam int IN_USED      = IN_PRIM_LSB + REQ_W;
  localparam int IN_W         = ((IN_USED + 7) / 8) * 8;

  localparam int OUT_USED = 2 * POS_W + HEAD_W + COST_W + STEP_W;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

  localparam int FLAG_ROT  = 0;
  localparam int FLAG_REV  = 1;
  localparam int FLAG_GEAR = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATE  = 2'd0,
    REG_REVERSE = 2'd1,
    REG_GEAR    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ARC_LEFT     = 2'd0,
    ARC_STRAIGHT = 2'd1,
    ARC_RIGHT    = 2'd2
  } arc_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  localparam logic [REQ_W-1:0]          PRIM_ROTATE    = 3'd0;
  localparam logic [REQ_W-1:0]          PRIM_BACK0     = 3'd3;
  localparam logic [REQ_W-1:0]          PRIM_LAST      = 3'd5;
  localparam logic signed [PPRIM_W-1:0] PPRIM_FWD_MAX  = 4'sd2;

  localparam logic [PEN_W-1:0]  PEN_ONE  = 16'd4096;
  localparam logic [PEN_W-1:0]  PEN_HALF = 16'd2048;
  localparam logic [HEAD_W-1:0] DT_TURN  = 16'd2458;

  localparam logic [MUL_W-1:0]         ONE_Q30  = 31'h4000_0000;
  localparam logic signed [TRIG_W-1:0] ONE_TRIG = 32'sh4000_0000;

  localparam logic signed [POLY_W-1:0] SIN_A1 = 32'sd1686629713;
  localparam logic signed [POLY_W-1:0] SIN_A3 = -32'sd693598668;
  localparam logic signed [POLY_W-1:0] SIN_A5 = 32'sd85569306;
  localparam logic signed [POLY_W-1:0] SIN_A7 = -32'sd5026995;
  localparam logic signed [POLY_W-1:0] SIN_A9 = 32'sd172273;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [HEAD_W-1:0]       head;
    logic [COST_W-1:0]       pcost;
    quad_t                   quad;
    logic [MUL_W-1:0]        z;
    logic [MUL_W-1:0]        zc;
    logic signed [DX_W-1:0]  fdx;
    logic signed [DY_W-1:0]  dy;
    logic [STEP_W-1:0]       step;
    logic [NUM_PEN-1:0]      pflags;
  } front_t;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [HEAD_W-1:0]       head;
    logic [COST_W-1:0]       cost;
    logic [STEP_W-1:0]       step;
    quad_t                   quad;
    logic signed [DX_W-1:0]  fdx;
    logic signed [DY_W-1:0]  dy;
    logic [MUL_W-1:0]        z;
    logic [MUL_W-1:0]        zc;
    logic [MUL_W-1:0]        z2;
    logic [MUL_W-1:0]        zc2;
  } mid_t;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [HEAD_W-1:0]       head;
    logic [COST_W-1:0]       cost;
    logic [STEP_W-1:0]       step;
  } tail_t;

  function automatic logic signed [DX_W-1:0] arc_dx(input arc_t k);
    logic signed [DX_W-1:0] r;
    case (k)
      ARC_STRAIGHT:        r = 18'sd92650;
      ARC_LEFT, ARC_RIGHT: r = 18'sd91794;
      default:             r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [DY_W-1:0] arc_dy(input arc_t k);
    logic signed [DY_W-1:0] r;
    case (k)
      ARC_LEFT:  r = -15'sd10865;
      ARC_RIGHT: r = 15'sd10865;
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [STEP_W-1:0] step_len(input arc_t k);
    logic [STEP_W-1:0] r;
    case (k)
      ARC_STRAIGHT:        r = 17'd92650;
      ARC_LEFT, ARC_RIGHT: r = 17'd92435;
      default:             r = '0;
    endcase
    return r;
  endfunction

  // Horner coefficient folded in by each cell of the sine chain
  function automatic logic signed [POLY_W-1:0] poly_coef(input int idx);
    logic signed [POLY_W-1:0] r;
    case (idx)
      0:       r = SIN_A7;
      1:       r = SIN_A5;
      2:       r = SIN_A3;
      3:       r = SIN_A1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/motion_primitive_successor_core.sv */
// Motion primitive successor: expands one parent pose by one of six arcs.
// Input items arrive on s_tvalid/s_tready/s_tdata and carry the parent pose,
// its cost, the primitive that made it and the requested primitive. Result
// items leave on m_tvalid/m_tready/m_tdata with the child pose, child cost
// and step length. An item with requested primitive 6 or 7 is taken and
// dropped without a result.
// The cfg port writes the rotate, reverse and gear-change penalties (Q4.12)
// at indexes 0..2; other indexes are ignored. Write only while idle.
// One item per cycle is sustained while m_tready is high. The sine/cosine
// unit is a chain of five Horner cells, two stages each, evaluating both
// quarter-wave polynomials side by side.
// Every stage holds its own valid bit, so bubbles are squeezed out and new
// items are taken while a result waits on a stalled receiver; s_tready
// falls only when all 20 stages are full.
// Reset empties the pipeline and sets all penalties to 1.0.
`timescale 1ns / 1ps
`default_nettype none

module motion_primitive_successor_core #(
  parameter int ANGLE_BITS = mps_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // parent_x, parent_y, parent_heading, parent_cost, parent_primitive, primitive_req
  input  wire logic [mps_pkg::IN_W-1:0]        s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // child_x, child_y, child_heading, child_cost, step_length
  output logic [mps_pkg::OUT_W-1:0]            m_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mps_pkg::PEN_W-1:0]       cfg_data
);
  import mps_pkg::*;

  localparam int Z_SHIFT = Q30 + 2 - ANGLE_BITS;
  localparam int SQ_W    = 2 * MUL_W;
  localparam logic signed [ROT_W-1:0] RND_POS = ROT_W'(64'sd1 <<< (Q30 - 1));
  localparam logic signed [ROT_W-1:0] RND_NEG = ROT_W'((64'sd1 <<< (Q30 - 1)) - 64'sd1);

  // penalty registers
  logic [PEN_W-1:0] pen [NUM_PEN];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PEN; i++) begin
        pen[i] <= PEN_ONE;
      end
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROTATE:  pen[FLAG_ROT]  <= cfg_data;
        REG_REVERSE: pen[FLAG_REV]  <= cfg_data;
        REG_GEAR:    pen[FLAG_GEAR] <= cfg_data;
        default: ;
      endcase
    end
  end

  // front stage
  logic signed [POS_W-1:0]   in_x;
  logic signed [POS_W-1:0]   in_y;
  logic [HEAD_W-1:0]         in_head;
  logic [COST_W-1:0]         in_cost;
  logic signed [PPRIM_W-1:0] in_pprim;
  logic [REQ_W-1:0]          in_prim;
  logic [ANGLE_BITS-1:0]     ang;
  logic                      backward;
  logic [REQ_W-1:0]          k_raw;
  arc_t                      k;
  front_t                    f_d;
  front_t                    f_q;
  logic                      f_v;
  logic                      f_load;

  assign in_x     = s_tdata[IN_X_LSB +: POS_W];
  assign in_y     = s_tdata[IN_Y_LSB +: POS_W];
  assign in_head  = s_tdata[IN_HEAD_LSB +: HEAD_W];
  assign in_cost  = s_tdata[IN_COST_LSB +: COST_W];
  assign in_pprim = s_tdata[IN_PPRIM_LSB +: PPRIM_W];
  assign in_prim  = s_tdata[IN_PRIM_LSB +: REQ_W];

  generate
    if (ANGLE_BITS >= HEAD_W) begin : g_ang_wide
      assign ang = ANGLE_BITS'(in_head) << (ANGLE_BITS - HEAD_W);
    end else begin : g_ang_narrow
      assign ang = in_head[HEAD_W-1 -: ANGLE_BITS];
    end
  endgenerate

  always_comb begin
    backward = in_prim >= PRIM_BACK0;
    k_raw    = backward ? in_prim - PRIM_BACK0 : in_prim;
    k        = arc_t'(k_raw[1:0]);

    f_d.px    = in_x;
    f_d.py    = in_y;
    f_d.pcost = in_cost;
    f_d.quad  = quad_t'(ang[ANGLE_BITS-1 -: 2]);
    f_d.z     = MUL_W'(ang[ANGLE_BITS-3:0]) << Z_SHIFT;
    f_d.zc    = ONE_Q30 - f_d.z;
    f_d.fdx   = backward ? -arc_dx(k) : arc_dx(k);
    f_d.dy    = arc_dy(k);
    f_d.step  = step_len(k);

    priority if (k == ARC_STRAIGHT) begin
      f_d.head = in_head;
    end else if ((k == ARC_LEFT) != backward) begin
      f_d.head = in_head + DT_TURN;
    end else begin
      f_d.head = in_head - DT_TURN;
    end

    f_d.pflags[FLAG_ROT]  = in_prim == PRIM_ROTATE;
    f_d.pflags[FLAG_REV]  = backward;
    f_d.pflags[FLAG_GEAR] = ($signed({1'b0, in_prim}) != in_pprim) &&
                            (backward || (in_pprim > PPRIM_FWD_MAX));
  end

  logic pen_v   [NUM_PEN+1];
  logic pen_rdy [NUM_PEN+1];
  logic [PCOST_W-1:0] pen_val [NUM_PEN+1];
  front_t pen_side [NUM_PEN+1];

  assign f_load   = !f_v || pen_rdy[0];
  assign s_tready = f_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (f_load) begin
      f_v <= s_tvalid && (in_prim <= PRIM_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (f_load && s_tvalid) begin
      f_q <= f_d;
    end
  end

  // penalty chain
  assign pen_v[0]    = f_v;
  assign pen_val[0]  = PCOST_W'(f_q.step);
  assign pen_side[0] = f_q;

  for (genvar i = 0; i < NUM_PEN; i++) begin : g_pen
    mps_pen_cell #(.SIDE_W($bits(front_t))) u_cell (
      .clk,
      .rst,
      .in_valid  (pen_v[i]),
      .in_ready  (pen_rdy[i]),
      .in_val    (pen_val[i]),
      .in_apply  (pen_side[i].pflags[i]),
      .pen       (pen[i]),
      .in_side   (pen_side[i]),
      .out_valid (pen_v[i+1]),
      .out_ready (pen_rdy[i+1]),
      .out_val   (pen_val[i+1]),
      .out_side  (pen_side[i+1])
    );
  end

  // squares and cost sum
  logic [SQ_W-1:0]   zsq;
  logic [SQ_W-1:0]   zcsq;
  logic [COST_W:0]   csum;
  front_t            fs;
  mid_t              q_d;
  mid_t              q_q;
  logic              q_v;
  logic              q_load;

  logic poly_v   [NUM_POLY+1];
  logic poly_rdy [NUM_POLY+1];
  logic signed [POLY_W-1:0] poly_pa [NUM_POLY+1];
  logic signed [POLY_W-1:0] poly_pb [NUM_POLY+1];
  mid_t poly_side [NUM_POLY+1];

  assign pen_rdy[NUM_PEN] = q_load;
  assign q_load           = !q_v || poly_rdy[0];

  always_comb begin
    fs    = pen_side[NUM_PEN];
    zsq   = SQ_W'(fs.z) * SQ_W'(fs.z);
    zcsq  = SQ_W'(fs.zc) * SQ_W'(fs.zc);
    csum  = {1'b0, fs.pcost} + (COST_W+1)'(pen_val[NUM_PEN]);

    q_d.px   = fs.px;
    q_d.py   = fs.py;
    q_d.head = fs.head;
    q_d.cost = csum[COST_W] ? '1 : csum[COST_W-1:0];
    q_d.step = fs.step;
    q_d.quad = fs.quad;
    q_d.fdx  = fs.fdx;
    q_d.dy   = fs.dy;
    q_d.z    = fs.z;
    q_d.zc   = fs.zc;
    q_d.z2   = zsq[Q30 +: MUL_W];
    q_d.zc2  = zcsq[Q30 +: MUL_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
    end else if (q_load) begin
      q_v <= pen_v[NUM_PEN];
    end
  end

  always_ff @(posedge clk) begin
    if (q_load && pen_v[NUM_PEN]) begin
      q_q <= q_d;
    end
  end

  // sine chain: lane a on z, lane b on 1 - z
  assign poly_v[0]    = q_v;
  assign poly_pa[0]   = SIN_A9;
  assign poly_pb[0]   = SIN_A9;
  assign poly_side[0] = q_q;

  for (genvar i = 0; i < NUM_POLY; i++) begin : g_poly
    mps_poly_cell #(.SIDE_W($bits(mid_t)), .COEF(poly_coef(i))) u_cell (
      .clk,
      .rst,
      .in_valid  (poly_v[i]),
      .in_ready  (poly_rdy[i]),
      .in_pa     (poly_pa[i]),
      .in_pb     (poly_pb[i]),
      .in_ma     ((i < NUM_POLY - 1) ? poly_side[i].z2 : poly_side[i].z),
      .in_mb     ((i < NUM_POLY - 1) ? poly_side[i].zc2 : poly_side[i].zc),
      .in_side   (poly_side[i]),
      .out_valid (poly_v[i+1]),
      .out_ready (poly_rdy[i+1]),
      .out_pa    (poly_pa[i+1]),
      .out_pb    (poly_pb[i+1]),
      .out_side  (poly_side[i+1])
    );
  end

  // clamp and quadrant mapping
  function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [POLY_W-1:0] p);
    logic signed [TRIG_W-1:0] r;
    priority if (p < 0) begin
      r = '0;
    end else if (p > ONE_TRIG) begin
      r = ONE_TRIG;
    end else begin
      r = p;
    end
    return r;
  endfunction

  mid_t                     ps;
  logic signed [TRIG_W-1:0] sz;
  logic signed [TRIG_W-1:0] sc;
  logic signed [TRIG_W-1:0] s_d;
  logic signed [TRIG_W-1:0] c_d;
  tail_t                    cl_tail;
  logic signed [TRIG_W-1:0] cl_s;
  logic signed [TRIG_W-1:0] cl_c;
  logic signed [DX_W-1:0]   cl_fdx;
  logic signed [DY_W-1:0]   cl_dy;
  logic                     cl_v;
  logic                     cl_load;

  logic                     pr_v;
  logic                     pr_load;
  tail_t                    pr_tail;
  logic signed [ROT_W-1:0]  pr_xc;
  logic signed [ROT_W-1:0]  pr_ys;
  logic signed [ROT_W-1:0]  pr_xs;
  logic signed [ROT_W-1:0]  pr_yc;

  logic                     df_v;
  logic                     df_load;
  tail_t                    df_tail;
  logic signed [ROT_W-1:0]  df_vx;
  logic signed [ROT_W-1:0]  df_vy;

  logic                     rd_v;
  logic                     rd_load;
  tail_t                    rd_tail;
  logic signed [POS_W-1:0]  rd_ox;
  logic signed [POS_W-1:0]  rd_oy;
  logic signed [ROT_W-1:0]  rx_sum;
  logic signed [ROT_W-1:0]  ry_sum;

  logic                     ot_v;
  logic                     ot_load;
  logic signed [POS_W-1:0]  ot_x;
  logic signed [POS_W-1:0]  ot_y;
  logic [HEAD_W-1:0]        ot_head;
  logic [COST_W-1:0]        ot_cost;
  logic [STEP_W-1:0]        ot_step;

  assign poly_rdy[NUM_POLY] = cl_load;
  assign cl_load = !cl_v || pr_load;
  assign pr_load = !pr_v || df_load;
  assign df_load = !df_v || rd_load;
  assign rd_load = !rd_v || ot_load;
  assign ot_load = !ot_v || m_tready;

  always_comb begin
    ps = poly_side[NUM_POLY];
    sz = clamp_unit(poly_pa[NUM_POLY]);
    sc = clamp_unit(poly_pb[NUM_POLY]);
    unique case (ps.quad)
      QUAD_0: begin s_d = sz;  c_d = sc;  end
      QUAD_1: begin s_d = sc;  c_d = -sz; end
      QUAD_2: begin s_d = -sz; c_d = -sc; end
      QUAD_3: begin s_d = -sc; c_d = sz;  end
      default: begin s_d = '0; c_d = '0; end
    endcase
  end

  // round half away from zero, Q46 -> Q16.16
  always_comb begin
    rx_sum = df_vx + (df_vx[ROT_W-1] ? RND_NEG : RND_POS);
    ry_sum = df_vy + (df_vy[ROT_W-1] ? RND_NEG : RND_POS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cl_v <= 1'b0;
      pr_v <= 1'b0;
      df_v <= 1'b0;
      rd_v <= 1'b0;
      ot_v <= 1'b0;
    end else begin
      if (cl_load) cl_v <= poly_v[NUM_POLY];
      if (pr_load) pr_v <= cl_v;
      if (df_load) df_v <= pr_v;
      if (rd_load) rd_v <= df_v;
      if (ot_load) ot_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cl_load && poly_v[NUM_POLY]) begin
      cl_tail.px   <= ps.px;
      cl_tail.py   <= ps.py;
      cl_tail.head <= ps.head;
      cl_tail.cost <= ps.cost;
      cl_tail.step <= ps.step;
      cl_s         <= s_d;
      cl_c         <= c_d;
      cl_fdx       <= ps.fdx;
      cl_dy        <= ps.dy;
    end
    if (pr_load && cl_v) begin
      pr_tail <= cl_tail;
      pr_xc   <= ROT_W'(cl_fdx) * ROT_W'(cl_c);
      pr_ys   <= ROT_W'(cl_dy) * ROT_W'(cl_s);
      pr_xs   <= ROT_W'(cl_fdx) * ROT_W'(cl_s);
      pr_yc   <= ROT_W'(cl_dy) * ROT_W'(cl_c);
    end
    if (df_load && pr_v) begin
      df_tail <= pr_tail;
      df_vx   <= pr_xc - pr_ys;
      df_vy   <= pr_xs + pr_yc;
    end
    if (rd_load && df_v) begin
      rd_tail <= df_tail;
      rd_ox   <= POS_W'(rx_sum >>> Q30);
      rd_oy   <= POS_W'(ry_sum >>> Q30);
    end
    if (ot_load && rd_v) begin
      ot_x    <= rd_tail.px + rd_ox;
      ot_y    <= rd_tail.py + rd_oy;
      ot_head <= rd_tail.head;
      ot_cost <= rd_tail.cost;
      ot_step <= rd_tail.step;
    end
  end

  assign m_tvalid = ot_v;
  assign m_tdata  = {(OUT_W - OUT_USED)'(0), ot_step, ot_cost, ot_head, ot_y, ot_x};

  a_bad_prim_dropped: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[IN_PRIM_LSB +: REQ_W] > PRIM_LAST) |=> !f_v)
    else $error("unknown primitive entered the pipeline");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the output stage is empty");

  a_step_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (ot_step == step_len(ARC_LEFT)) || (ot_step == step_len(ARC_STRAIGHT)))
    else $error("step length not from the arc table");

endmodule

`default_nettype wire

/* rtl/core/mps_pen_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module mps_pen_cell #(
  parameter int SIDE_W = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [mps_pkg::PCOST_W-1:0]  in_val,
  input  wire logic                         in_apply,
  input  wire logic [mps_pkg::PEN_W-1:0]    pen,
  input  wire logic [SIDE_W-1:0]            in_side,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [mps_pkg::PCOST_W-1:0]       out_val,
  output logic [SIDE_W-1:0]                 out_side
);
  import mps_pkg::*;

  localparam int PROD_W = PCOST_W + PEN_W;

  logic              load;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rnd;

  assign load     = !out_valid || out_ready;
  assign in_ready = load;

  always_comb begin
    prod = PROD_W'(in_val) * PROD_W'(pen);
    rnd  = prod + PROD_W'(PEN_HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_val  <= in_apply ? rnd[PEN_FRAC +: PCOST_W] : in_val;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mps_poly_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module mps_poly_cell #(
  parameter int                                 SIDE_W = 1,
  parameter logic signed [mps_pkg::POLY_W-1:0]  COEF   = '0
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [mps_pkg::POLY_W-1:0]  in_pa,
  input  wire logic signed [mps_pkg::POLY_W-1:0]  in_pb,
  input  wire logic [mps_pkg::MUL_W-1:0]          in_ma,
  input  wire logic [mps_pkg::MUL_W-1:0]          in_mb,
  input  wire logic [SIDE_W-1:0]                  in_side,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [mps_pkg::POLY_W-1:0]       out_pa,
  output logic signed [mps_pkg::POLY_W-1:0]       out_pb,
  output logic [SIDE_W-1:0]                       out_side
);
  import mps_pkg::*;

  localparam int PROD_W = 2 * POLY_W;
  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((64'sd1 <<< Q30) - 64'sd1);

  logic                     va;
  logic                     load_a;
  logic                     load_b;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic [SIDE_W-1:0]        side_a;

  // Q30 product, truncated toward zero
  function automatic logic signed [POLY_W-1:0] trunc_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    biased = p[PROD_W-1] ? p + TRUNC_BIAS : p;
    return POLY_W'(biased >>> Q30);
  endfunction

  assign load_b   = !out_valid || out_ready;
  assign load_a   = !va || load_b;
  assign in_ready = load_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_a) begin
        va <= in_valid;
      end
      if (load_b) begin
        out_valid <= va;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_a && in_valid) begin
      prod_a <= PROD_W'(in_pa) * PROD_W'($signed({1'b0, in_ma}));
      prod_b <= PROD_W'(in_pb) * PROD_W'($signed({1'b0, in_mb}));
      side_a <= in_side;
    end
    if (load_b && va) begin
      out_pa   <= trunc_q30(prod_a) + COEF;
      out_pb   <= trunc_q30(prod_b) + COEF;
      out_side <= side_a;
    end
  end

endmodule

`default_nettype wire
